// ===== hdl/spa_pkg.sv =====
// Shared constants, request codes and controller/datapath signal groups.
package spa_pkg;

   localparam int MAX_TERMS = 32;
   localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int COEFF_W   = 16;
   localparam int EXP_W     = 8;
   localparam int SUM_W     = COEFF_W + 1;
   localparam int REQ_W     = 2;

   localparam logic [REQ_W-1:0] REQ_LOAD_FIRST  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOAD_SECOND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START       = 2'd2;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic step;
   } spa_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } spa_status_type;

endpackage

// ===== hdl/spa_if.sv =====
// Request and response channel interfaces.
interface spa_req_if;
   logic                               valid;
   logic                               ready;
   logic [spa_pkg::REQ_W-1:0]          req_type;
   logic signed [spa_pkg::COEFF_W-1:0] term_coeff;
   logic [spa_pkg::EXP_W-1:0]          term_exponent;

   modport source (output valid, req_type, term_coeff, term_exponent, input ready);
   modport sink (input valid, req_type, term_coeff, term_exponent, output ready);
endinterface

interface spa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [spa_pkg::SUM_W-1:0] sum_coeff;
   logic [spa_pkg::EXP_W-1:0]        out_exponent;
   logic                             last_term;
   logic                             no_terms;

   modport source (output valid, sum_coeff, out_exponent, last_term, no_terms, input ready);
   modport sink (input valid, sum_coeff, out_exponent, last_term, no_terms, output ready);
endinterface

// ===== hdl/spa_datapath.sv =====
// Term list memories, merge indices, compare/add logic and the output register.
module spa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  spa_pkg::spa_cmd_type               cmd,
   output spa_pkg::spa_status_type            status,
   input  logic signed [spa_pkg::COEFF_W-1:0] in_coeff,
   input  logic [spa_pkg::EXP_W-1:0]          in_exponent,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [spa_pkg::SUM_W-1:0]   out_coeff,
   output logic [spa_pkg::EXP_W-1:0]          out_exponent,
   output logic                               out_last,
   output logic                               out_none
);
   import spa_pkg::*;

   logic [COEFF_W+EXP_W-1:0] first_mem [MAX_TERMS];
   logic [COEFF_W+EXP_W-1:0] second_mem [MAX_TERMS];

   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic [CNT_W-1:0] first_idx_ff, first_idx_in;
   logic [CNT_W-1:0] second_idx_ff, second_idx_in;

   // Head registers hold the entry at the current index, as read from the term memories.
   logic [COEFF_W+EXP_W-1:0] first_head_ff, second_head_ff;

   logic                      valid_ff, valid_in;
   logic signed [SUM_W-1:0]   coeff_ff, coeff_in;
   logic [EXP_W-1:0]          exp_ff, exp_in;
   logic                      last_ff, last_in;
   logic                      none_ff, none_in;

   logic signed [COEFF_W-1:0] a_coeff, b_coeff;
   logic [EXP_W-1:0]          a_exp, b_exp;
   logic                      a_ok, b_ok, take_a, take_b, last;

   assign a_coeff = first_head_ff[COEFF_W+EXP_W-1:EXP_W];
   assign a_exp   = first_head_ff[EXP_W-1:0];
   assign b_coeff = second_head_ff[COEFF_W+EXP_W-1:EXP_W];
   assign b_exp   = second_head_ff[EXP_W-1:0];

   assign a_ok = first_idx_ff < first_count_ff;
   assign b_ok = second_idx_ff < second_count_ff;

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (a_ok && b_ok) begin
         take_a = a_exp >= b_exp;
         take_b = b_exp >= a_exp;
      end else begin
         take_a = a_ok;
         take_b = b_ok;
      end
   end

   always_comb begin
      first_idx_in  = first_idx_ff;
      second_idx_in = second_idx_ff;
      if (take_a) begin
         first_idx_in = first_idx_ff + CNT_W'(1);
      end
      if (take_b) begin
         second_idx_in = second_idx_ff + CNT_W'(1);
      end
      last = (first_idx_in >= first_count_ff) && (second_idx_in >= second_count_ff);
      if (cmd.step && last) begin
         first_idx_in  = '0;
         second_idx_in = '0;
      end else if (!cmd.step) begin
         first_idx_in  = first_idx_ff;
         second_idx_in = second_idx_ff;
      end
   end

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (cmd.load_first && first_count_ff < CNT_W'(MAX_TERMS)) begin
         first_count_in = first_count_ff + CNT_W'(1);
      end
      if (cmd.load_second && second_count_ff < CNT_W'(MAX_TERMS)) begin
         second_count_in = second_count_ff + CNT_W'(1);
      end
      if (cmd.step && last) begin
         first_count_in  = '0;
         second_count_in = '0;
      end
   end

   always_comb begin
      coeff_in = coeff_ff;
      exp_in   = exp_ff;
      last_in  = last_ff;
      none_in  = none_ff;
      valid_in = valid_ff && !out_ready;
      if (cmd.step) begin
         valid_in = 1'b1;
         last_in  = last;
         none_in  = !a_ok && !b_ok;
         if (take_a && take_b) begin
            coeff_in = SUM_W'(a_coeff) + SUM_W'(b_coeff);
            exp_in   = a_exp;
         end else if (take_a) begin
            coeff_in = SUM_W'(a_coeff);
            exp_in   = a_exp;
         end else if (take_b) begin
            coeff_in = SUM_W'(b_coeff);
            exp_in   = b_exp;
         end else begin
            coeff_in = '0;
            exp_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_first && first_count_ff < CNT_W'(MAX_TERMS)) begin
         first_mem[first_count_ff[ADDR_W-1:0]] <= {in_coeff, in_exponent};
      end
      if (cmd.load_second && second_count_ff < CNT_W'(MAX_TERMS)) begin
         second_mem[second_count_ff[ADDR_W-1:0]] <= {in_coeff, in_exponent};
      end
      first_head_ff  <= first_mem[first_idx_in[ADDR_W-1:0]];
      second_head_ff <= second_mem[second_idx_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_idx_ff    <= '0;
         second_idx_ff   <= '0;
         valid_ff        <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_idx_ff    <= first_idx_in;
         second_idx_ff   <= second_idx_in;
         valid_ff        <= valid_in;
      end
      coeff_ff <= coeff_in;
      exp_ff   <= exp_in;
      last_ff  <= last_in;
      none_ff  <= none_in;
   end

   assign status.out_free = !valid_ff || out_ready;
   assign status.last     = last;

   assign out_valid    = valid_ff;
   assign out_coeff    = coeff_ff;
   assign out_exponent = exp_ff;
   assign out_last     = last_ff;
   assign out_none     = none_ff;

endmodule

// ===== hdl/spa_ctrl.sv =====
// Controller: decodes requests and sequences the merge walk.
module spa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [spa_pkg::REQ_W-1:0] req_type,
   output spa_pkg::spa_cmd_type     cmd,
   input  spa_pkg::spa_status_type  status
);
   import spa_pkg::*;

   typedef enum logic {IDLE, MERGE} state_type;

   state_type state_ff;
   logic      accept;

   assign req_ready = state_ff == IDLE;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      case (state_ff)
         IDLE: begin
            cmd.load_first  = accept && req_type == REQ_LOAD_FIRST;
            cmd.load_second = accept && req_type == REQ_LOAD_SECOND;
         end
         MERGE: begin
            cmd.step = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept && req_type == REQ_START) begin
                  state_ff <= MERGE;
               end
            end
            MERGE: begin
               if (status.out_free && status.last) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/sparse_polynomial_add.sv =====
// Top level of the sparse polynomial adder.
//
//   channel   direction   fields
//   req_ch    in          req_type, term_coeff, term_exponent
//   rsp_ch    out         sum_coeff, out_exponent, last_term, no_terms
//
// Loads may arrive back to back.
// A start walks both lists, one result term per cycle while rsp is taken, and
// holds req ready low until the last term (or a no_terms result for an empty
// add) is stepped out; the single read port of each term memory sets that pace.
// Reset (synchronous) empties both lists; the memories themselves are not cleared.
// A stalled rsp channel holds the walk; loads are taken only once the walk ends, even while its last result waits.
module sparse_polynomial_add (
   input logic      clock,
   input logic      reset,
   spa_req_if.sink  req_ch,
   spa_rsp_if.source rsp_ch
);
   import spa_pkg::*;

   spa_cmd_type    cmd;
   spa_status_type status;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_type  (req_ch.req_type),
      .cmd       (cmd),
      .status    (status)
   );

   spa_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_coeff     (req_ch.term_coeff),
      .in_exponent  (req_ch.term_exponent),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_coeff    (rsp_ch.sum_coeff),
      .out_exponent (rsp_ch.out_exponent),
      .out_last     (rsp_ch.last_term),
      .out_none     (rsp_ch.no_terms)
   );

endmodule
